@@ design/byte_pattern_first_last_search_core_defines.svh @@
// Assertion macros used by the checker file of the pattern search core.
`ifndef BYTE_PATTERN_FIRST_LAST_SEARCH_CORE_DEFINES_SVH
`define BYTE_PATTERN_FIRST_LAST_SEARCH_CORE_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define BPFL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define BPFL_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/bpfl_pkg.sv @@
// Package with constants, types and helper functions of the pattern search core.
package bpfl_pkg;

	localparam int PATTERN_MAX = 16;
	localparam int TEXT_MAX    = 65536;
	localparam int LEN_W       = 5;
	localparam int IDX_W       = $clog2(PATTERN_MAX);
	localparam int POS_W       = $clog2(TEXT_MAX);
	localparam int CNT_W       = POS_W + 1;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 64;

	typedef logic [7:0] byte_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PATTERN_LOWER  = 2'd0,
		CFG_PATTERN_UPPER  = 2'd1,
		CFG_PATTERN_LENGTH = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] lower;
		logic [CFG_DATA_W-1:0] upper;
		logic [LEN_W-1:0]      length;
	} pattern_cfg_t;

	function automatic logic [LEN_W-1:0] used_length(input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] res;
		res = len;
		if (len == '0)
			res = LEN_W'(1);
		else if (len > LEN_W'(PATTERN_MAX))
			res = LEN_W'(PATTERN_MAX);
		return res;
	endfunction

	function automatic byte_t pattern_byte(input pattern_cfg_t cfg, input int k);
		logic [2*CFG_DATA_W-1:0] both;
		both = {cfg.upper, cfg.lower};
		return both[k*8 +: 8];
	endfunction

endpackage

@@ design/bpfl_match.sv @@
// Parallel compare of the newest window bytes with the configured pattern.
module bpfl_match (
	input  bpfl_pkg::pattern_cfg_t cfg,
	input  bpfl_pkg::byte_t        window [bpfl_pkg::PATTERN_MAX],
	output logic                   hit
);

	logic [bpfl_pkg::LEN_W-1:0] len;
	logic [bpfl_pkg::LEN_W-1:0] idx [bpfl_pkg::PATTERN_MAX];
	logic [bpfl_pkg::PATTERN_MAX-1:0] lane_ok;

	assign len = bpfl_pkg::used_length(cfg.length);

	// Pattern byte k lines up with the window entry len-1-k.
	always_comb begin
		for (int k = 0; k < bpfl_pkg::PATTERN_MAX; k++) begin
			idx[k] = len - bpfl_pkg::LEN_W'(1) - bpfl_pkg::LEN_W'(k);
			if (bpfl_pkg::LEN_W'(k) >= len)
				lane_ok[k] = 1'b1;
			else
				lane_ok[k] = (window[idx[k][bpfl_pkg::IDX_W-1:0]] ==
					bpfl_pkg::pattern_byte(cfg, k));
		end
	end

	assign hit = &lane_ok;

endmodule

@@ design/byte_pattern_first_last_search_core.sv @@
// Top level of the streaming byte pattern search with first and last match report.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------
//  text     | text_valid/text_stall | text_byte, end_of_text
//  result   | result_valid/         | first_found, first_start, last_found,
//           | result_stall          | last_start, length_overflow
//  config   | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// One text beat is taken every cycle while text_stall is low; the window compare
// and the state update sit between the input register and the result register,
// which holds the result beat until it is taken.
// Reset clears the handshakes, the byte count and the match flags; the
// pattern resets to length one, all zero bytes.
// A stalled result holds back only a following end-of-text beat.
module byte_pattern_first_last_search_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                text_valid,
	output logic                                text_stall,
	input  logic [7:0]                          text_byte,
	input  logic                                end_of_text,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic                                first_found,
	output logic [15:0]                         first_start,
	output logic                                last_found,
	output logic [15:0]                         last_start,
	output logic                                length_overflow,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bpfl_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [bpfl_pkg::CFG_DATA_W-1:0]     cfg_data
);

	bpfl_pkg::pattern_cfg_t cfg_q;

	logic                  valid_s1;
	bpfl_pkg::byte_t       byte_s1;
	logic                  eot_s1;

	bpfl_pkg::byte_t       window_q [bpfl_pkg::PATTERN_MAX];
	bpfl_pkg::byte_t       window_next [bpfl_pkg::PATTERN_MAX];
	logic [bpfl_pkg::CNT_W-1:0] count_q;
	logic [bpfl_pkg::CNT_W-1:0] count_inc;
	logic                  early_valid_q, late_valid_q, ovf_q;
	logic [bpfl_pkg::POS_W-1:0] early_start_q, late_start_q;

	logic                  early_valid_n, late_valid_n, ovf_n;
	logic [bpfl_pkg::POS_W-1:0] early_start_n, late_start_n, start;
	logic [bpfl_pkg::LEN_W-1:0] len;
	logic                  accept, advance, store, hit_raw, hit;

	assign cfg_ready  = 1'b1;
	assign advance    = valid_s1 && !(eot_s1 && result_valid && result_stall);
	assign text_stall = valid_s1 && eot_s1 && result_valid && result_stall;
	assign accept     = text_valid && !text_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lower  <= '0;
			cfg_q.upper  <= '0;
			cfg_q.length <= bpfl_pkg::LEN_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (bpfl_pkg::cfg_index_t'(cfg_index))
				bpfl_pkg::CFG_PATTERN_LOWER:  cfg_q.lower  <= cfg_data;
				bpfl_pkg::CFG_PATTERN_UPPER:  cfg_q.upper  <= cfg_data;
				bpfl_pkg::CFG_PATTERN_LENGTH: cfg_q.length <= cfg_data[bpfl_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= text_byte;
			eot_s1  <= end_of_text;
		end
	end

	always_comb begin
		window_next[0] = byte_s1;
		for (int i = 1; i < bpfl_pkg::PATTERN_MAX; i++)
			window_next[i] = window_q[i-1];
	end

	bpfl_match u_match (
		.cfg    (cfg_q),
		.window (window_next),
		.hit    (hit_raw)
	);

	assign len       = bpfl_pkg::used_length(cfg_q.length);
	assign store     = advance && !count_q[bpfl_pkg::POS_W];
	assign count_inc = count_q + bpfl_pkg::CNT_W'(1);
	assign start     = bpfl_pkg::POS_W'(count_inc - bpfl_pkg::CNT_W'(len));
	assign hit       = store && (count_inc >= bpfl_pkg::CNT_W'(len)) && hit_raw;

	assign early_valid_n = early_valid_q || hit;
	assign early_start_n = (hit && !early_valid_q) ? start : early_start_q;
	assign late_valid_n  = late_valid_q || hit;
	assign late_start_n  = hit ? start : late_start_q;
	assign ovf_n         = ovf_q || (advance && count_q[bpfl_pkg::POS_W]);

	always_ff @(posedge clk) begin
		if (store) begin
			for (int i = 0; i < bpfl_pkg::PATTERN_MAX; i++)
				window_q[i] <= window_next[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			early_valid_q <= 1'b0;
			early_start_q <= '0;
			late_valid_q  <= 1'b0;
			late_start_q  <= '0;
			ovf_q         <= 1'b0;
		end else if (advance) begin
			if (eot_s1) begin
				count_q       <= '0;
				early_valid_q <= 1'b0;
				early_start_q <= '0;
				late_valid_q  <= 1'b0;
				late_start_q  <= '0;
				ovf_q         <= 1'b0;
			end else begin
				if (store)
					count_q <= count_inc;
				early_valid_q <= early_valid_n;
				early_start_q <= early_start_n;
				late_valid_q  <= late_valid_n;
				late_start_q  <= late_start_n;
				ovf_q         <= ovf_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance && eot_s1) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && eot_s1) begin
			first_found     <= early_valid_n;
			first_start     <= early_start_n;
			last_found      <= late_valid_n;
			last_start      <= late_start_n;
			length_overflow <= ovf_n;
		end
	end

endmodule

@@ design/bpfl_checker.sv @@
// Port-level checker of the pattern search core and its bind statement.
`include "byte_pattern_first_last_search_core_defines.svh"

module bpfl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_stall,
	input logic        first_found,
	input logic [15:0] first_start,
	input logic        last_found,
	input logic [15:0] last_start,
	input logic        length_overflow
);

	// A stalled result beat stays and keeps its start offsets and overflow flag.
	`BPFL_ASSERT(a_result_hold, result_valid && result_stall |=> result_valid && $stable(first_start) && $stable(last_start) && $stable(length_overflow), "stalled result changed")

	// Both searches see the same set of matches.
	`BPFL_ASSERT(a_found_agree, result_valid |-> first_found == last_found, "found flags disagree")

	// With no match both start offsets read zero.
	`BPFL_ASSERT(a_none_zero, result_valid && !first_found |-> first_start == 16'd0 && last_start == 16'd0, "start offsets nonzero without a match")

	// The earliest match never lies after the latest one.
	`BPFL_ASSERT(a_order, result_valid && first_found |-> first_start <= last_start, "first start after last start")

endmodule

bind byte_pattern_first_last_search_core bpfl_checker u_bpfl_checker (.*);

@@ sim/testbench.sv @@
// Self-checking testbench for the byte pattern first and last match search core.
`timescale 1ns / 100ps

module testbench;
	import bpfl_pkg::*;

	localparam int CLK_HALF      = 6;
	localparam int CYCLE_LIMIT   = 2000000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_BEATS  = 1150;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 2'd3;

	typedef struct packed {
		logic        first_found;
		logic [15:0] first_start;
		logic        last_found;
		logic [15:0] last_start;
		logic        length_overflow;
	} search_report_t;

	class search_scoreboard;
		logic [CFG_DATA_W-1:0] pat_lo;
		logic [CFG_DATA_W-1:0] pat_hi;
		logic [LEN_W-1:0]      pat_len;
		byte_t                 window [PATTERN_MAX];
		int unsigned           seen;
		bit                    early_ok;
		logic [15:0]           early_pos;
		bit                    late_ok;
		logic [15:0]           late_pos;
		bit                    ovf;
		search_report_t        pending [$];
		int                    errors;
		int                    reports_checked;
		int                    text_beats;

		function new();
			pat_lo = '0;
			pat_hi = '0;
			pat_len = LEN_W'(1);
			errors = 0;
			reports_checked = 0;
			text_beats = 0;
			clear_text();
		endfunction

		function void clear_text();
			foreach (window[i])
				window[i] = '0;
			seen = 0;
			early_ok = 0;
			early_pos = '0;
			late_ok = 0;
			late_pos = '0;
			ovf = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_PATTERN_LOWER:  pat_lo = data;
				CFG_PATTERN_UPPER:  pat_hi = data;
				CFG_PATTERN_LENGTH: pat_len = data[LEN_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned effective_length();
			int unsigned n;
			n = pat_len;
			if (n == 0)
				n = 1;
			if (n > PATTERN_MAX)
				n = PATTERN_MAX;
			return n;
		endfunction

		function byte_t pattern_at(int k);
			logic [2*CFG_DATA_W-1:0] both;
			both = {pat_hi, pat_lo};
			return both[k*8 +: 8];
		endfunction

		function void note_text(byte_t b, bit eot);
			int unsigned    len;
			bit             hit;
			search_report_t rep;
			text_beats++;
			if (seen >= TEXT_MAX) begin
				ovf = 1;
			end else begin
				for (int i = PATTERN_MAX - 1; i > 0; i--)
					window[i] = window[i-1];
				window[0] = b;
				seen++;
				len = effective_length();
				if (seen >= len) begin
					hit = 1;
					for (int k = 0; k < len; k++)
						if (window[len-1-k] != pattern_at(k))
							hit = 0;
					if (hit) begin
						if (!early_ok) begin
							early_ok = 1;
							early_pos = 16'(seen - len);
						end
						late_ok = 1;
						late_pos = 16'(seen - len);
					end
				end
			end
			if (eot) begin
				rep.first_found = early_ok;
				rep.first_start = early_ok ? early_pos : 16'd0;
				rep.last_found = late_ok;
				rep.last_start = late_ok ? late_pos : 16'd0;
				rep.length_overflow = ovf;
				pending.insert(pending.size(), rep);
				clear_text();
			end
		endfunction

		function void check_result(search_report_t got);
			search_report_t want;
			if (pending.size() == 0) begin
				$error("search report with no text closed: first %0d/%0d last %0d/%0d ovf %0d",
					got.first_found, got.first_start, got.last_found, got.last_start,
					got.length_overflow);
				errors++;
				return;
			end
			want = pending.pop_front();
			reports_checked++;
			if (got.first_found !== want.first_found) begin
				$error("first_found: expected %0d, actual %0d", want.first_found, got.first_found);
				errors++;
			end
			if (got.first_start !== want.first_start) begin
				$error("first_start: expected %0d, actual %0d", want.first_start, got.first_start);
				errors++;
			end
			if (got.last_found !== want.last_found) begin
				$error("last_found: expected %0d, actual %0d", want.last_found, got.last_found);
				errors++;
			end
			if (got.last_start !== want.last_start) begin
				$error("last_start: expected %0d, actual %0d", want.last_start, got.last_start);
				errors++;
			end
			if (got.length_overflow !== want.length_overflow) begin
				$error("length_overflow: expected %0d, actual %0d",
					want.length_overflow, got.length_overflow);
				errors++;
			end
		endfunction
	endclass

	logic                   clk = 0;
	logic                   arst_n = 0;
	logic                   text_valid = 0;
	logic                   text_stall;
	logic [7:0]             text_byte = '0;
	logic                   end_of_text = 0;
	logic                   result_valid;
	logic                   result_stall = 0;
	logic                   first_found;
	logic [15:0]            first_start;
	logic                   last_found;
	logic [15:0]            last_start;
	logic                   length_overflow;
	logic                   cfg_valid = 0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	search_scoreboard sb;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int cfg_writes = 0;
	int random_beats = 0;

	byte_pattern_first_last_search_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.text_valid     (text_valid),
		.text_stall     (text_stall),
		.text_byte      (text_byte),
		.end_of_text    (end_of_text),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.first_found    (first_found),
		.first_start    (first_start),
		.last_found     (last_found),
		.last_start     (last_start),
		.length_overflow(length_overflow),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #(CLK_HALF) clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (arst_n && result_valid && !result_stall)
			sb.check_result('{first_found, first_start, last_found, last_start, length_overflow});
	end

	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("byte_pattern_first_last_search_core regression: fail");
		$finish;
	end

	task automatic send_text_beat(input byte_t b, input bit eot);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			text_valid <= 0;
			@(negedge clk);
		end
		text_valid <= 1;
		text_byte <= b;
		end_of_text <= eot;
		do
			@(posedge clk);
		while (text_stall);
		sb.note_text(b, eot);
	endtask

	task automatic send_text(input byte_t txt [$]);
		foreach (txt[i])
			send_text_beat(txt[i], i == txt.size() - 1);
	endtask

	task automatic settle_block(input bit quiet_tail);
		@(negedge clk);
		text_valid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		if (quiet_tail)
			repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.write_reg(idx, data);
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic configure_random(input int set_no);
		logic [CFG_DATA_W-1:0] lo;
		logic [CFG_DATA_W-1:0] hi;
		logic [CFG_DATA_W-1:0] len_word;
		logic [LEN_W-1:0]      len;
		byte_t                 fill;
		lo = {$urandom, $urandom};
		hi = {$urandom, $urandom};
		if ($urandom_range(3) == 0) begin
			fill = 8'($urandom);
			lo = {8{fill}};
			hi = {8{fill}};
		end
		case (set_no % 6)
			0: len = LEN_W'(16);
			1: len = LEN_W'(1);
			2: len = LEN_W'(0);
			3: len = LEN_W'($urandom_range(17, 31));
			default: len = LEN_W'($urandom_range(2, 15));
		endcase
		len_word = {$urandom, $urandom};
		len_word[LEN_W-1:0] = len;
		cfg_write(CFG_PATTERN_LOWER, lo);
		cfg_write(CFG_PATTERN_UPPER, hi);
		cfg_write(CFG_PATTERN_LENGTH, len_word);
		if ($urandom_range(7) == 0)
			cfg_write(CFG_SPARE_INDEX, {$urandom, $urandom});
	endtask

	task automatic make_random_text(output byte_t txt [$]);
		int unsigned L;
		int unsigned n;
		int unsigned style;
		int unsigned off;
		L = sb.effective_length();
		n = ($urandom_range(29) == 0) ? $urandom_range(60, 300) : $urandom_range(1, 2 * L + 10);
		style = $urandom_range(3);
		txt = {};
		for (int i = 0; i < n; i++) begin
			if (style == 1 && $urandom_range(7) != 0)
				txt.insert(txt.size(), sb.pattern_at($urandom_range(L - 1)));
			else
				txt.insert(txt.size(), 8'($urandom));
		end
		if (style >= 2 && n >= L) begin
			repeat ($urandom_range(1, 3)) begin
				off = $urandom_range(n - L);
				for (int k = 0; k < L; k++)
					txt[off + k] = sb.pattern_at(k);
				if (style == 3)
					txt[off + $urandom_range(L - 1)] ^= 8'(1 << $urandom_range(7));
			end
		end
	endtask

	initial begin
		byte_t txt [$];
		int    set_no;
		int    phase_beats;
		sb = new();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// Reset pattern is a single zero byte.
		send_text({8'h00, 8'hFF, 8'h00});
		send_text({8'hFF});

		settle_block(1);
		cfg_write(CFG_PATTERN_LOWER, '0);
		cfg_write(CFG_PATTERN_UPPER, '0);
		cfg_write(CFG_PATTERN_LENGTH, CFG_DATA_W'(4));
		send_text({8'h00, 8'h00, 8'h00});
		send_text({8'h00, 8'h00, 8'h00, 8'h00});

		settle_block(1);
		cfg_write(CFG_PATTERN_LOWER, 64'h00000000000000FF);
		cfg_write(CFG_PATTERN_LENGTH, CFG_DATA_W'(0));
		send_text({8'hFF, 8'h01, 8'hFF});

		settle_block(1);
		cfg_write(CFG_PATTERN_LOWER, 64'hF0E1D2C3B4A59687);
		cfg_write(CFG_PATTERN_UPPER, 64'h78695A4B3C2D1E0F);
		cfg_write(CFG_PATTERN_LENGTH, {{(CFG_DATA_W-LEN_W){1'b1}}, 5'd31});
		cfg_write(CFG_SPARE_INDEX, '1);
		txt = {};
		for (int k = 0; k < PATTERN_MAX; k++)
			txt.insert(txt.size(), sb.pattern_at(k));
		send_text(txt);

		set_no = 0;
		while (random_beats < RANDOM_BEATS) begin
			settle_block(1);
			case (set_no % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 88; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 88; end
				default: begin send_idle_pct = 6; stall_pct = 6; end
			endcase
			configure_random(set_no);
			phase_beats = 0;
			while (phase_beats < 50 && random_beats < RANDOM_BEATS) begin
				if ($urandom_range(15) == 0)
					settle_block(0);
				make_random_text(txt);
				send_text(txt);
				phase_beats += txt.size();
				random_beats += txt.size();
			end
			set_no++;
		end

		settle_block(1);
		$display("Summary: %0d text beats, %0d search reports compared, %0d register writes.",
			sb.text_beats, sb.reports_checked, cfg_writes);
		$display("Covered clamped lengths, short texts, planted and broken matches, four idle mixes.");
		if (sb.errors == 0)
			$display("byte_pattern_first_last_search_core regression: pass");
		else
			$display("byte_pattern_first_last_search_core regression: fail");
		$finish;
	end

endmodule
